FILE: src/sgnms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sobel / non-maximum suppression package
// Shared constants, types and the angle sector decision.
// ----------------------------------------------------------------------------
package sgnms_pkg;

  localparam int unsigned MaxWidthDefault = 1024;
  localparam int unsigned PixW     = 8;
  localparam int unsigned RowW     = 13;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned MagW     = 21;
  localparam int unsigned EdgeW    = 11;
  localparam int unsigned GradW    = 12;
  localparam int unsigned AbsW     = 11;
  localparam int unsigned ProdW    = 37;
  localparam int unsigned SqrtW    = MagW + 1;

  localparam int unsigned WidthReset  = 640;
  localparam int unsigned HeightReset = 480;
  localparam int unsigned HeightMax   = 4096;
  localparam int unsigned DimMin      = 3;

  localparam logic [CfgIdxW-1:0] CfgIdxWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxHeight = CfgIdxW'(1);

  // tan(22.5 deg) and tan(67.5 deg) scaled by 2^24.
  localparam logic [22:0] TanLo = 23'd6949350;
  localparam logic [25:0] TanHi = 26'd40503782;

  typedef enum logic [1:0] {
    SecHorz,
    SecDiagUp,
    SecVert,
    SecDiagDown
  } sector_e;

  typedef enum logic [2:0] {
    FrIdle,
    FrWindow,
    FrGrad,
    FrMag,
    FrPush
  } front_state_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkWindow,
    BkNms,
    BkSqrt,
    BkOut
  } back_state_e;

  typedef struct packed {
    logic            out_valid;
    logic            interior;
    logic            last;
    logic            slot;
    logic [MagW-1:0] magsq;
    sector_e         sector;
  } nms_item_t;

  // neg: folded sx is negative; zero: both gradients are zero.
  function automatic sector_e sector_of(input logic neg, input logic zero,
                                        input logic [ProdW-1:0] lhs,
                                        input logic [ProdW-1:0] lo,
                                        input logic [ProdW-1:0] hi);
    sector_e s;
    s = SecHorz;
    if (zero) begin
      s = SecHorz;
    end else if (!neg) begin
      if (lhs < lo) s = SecHorz;
      else if (lhs < hi) s = SecDiagUp;
      else s = SecVert;
    end else begin
      if (lhs <= lo) s = SecHorz;
      else if (lhs <= hi) s = SecDiagDown;
      else s = SecVert;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: src/sgnms_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stream interfaces
// Pixel request channel and edge result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sgnms_pix_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [sgnms_pkg::PixW-1:0]    pixel;

  modport source (output valid, action, pixel, input ready);
  modport sink   (input valid, action, pixel, output ready);
endinterface

interface sgnms_res_if;
  logic                          valid;
  logic                          ready;
  logic [sgnms_pkg::EdgeW-1:0]   edge_value;
  logic                          frame_end;

  modport source (output valid, edge_value, frame_end, input ready);
  modport sink   (input valid, edge_value, frame_end, output ready);
endinterface
`default_nettype wire

FILE: src/sgnms_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Item queue
// Four-entry FIFO between the gradient front end and the suppression back end.
// ----------------------------------------------------------------------------
module sgnms_queue import sgnms_pkg::*; #(
  parameter int unsigned DataW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [DataW-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [DataW-1:0]      data_o,
  output logic                  empty_o
);

  logic [DataW-1:0] store_q [4];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + 2'd1 : wr_q;
    rd_d  = pop_i ? rd_q + 2'd1 : rd_q;
    cnt_d = cnt_q + 3'(push_i) - 3'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) store_q[wr_q] <= data_i;
  end

  assign data_o  = store_q[rd_q];
  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);

endmodule
`default_nettype wire

FILE: src/sgnms_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gradient front end
// Tracks the raster position, keeps two pixel rows, forms the Sobel
// gradients, squared magnitude and sector, and queues them for suppression.
// ----------------------------------------------------------------------------
module sgnms_front import sgnms_pkg::*; #(
  parameter  int unsigned MaxWidth = MaxWidthDefault,
  localparam int unsigned CW       = $clog2(MaxWidth),
  localparam int unsigned WW       = $clog2(MaxWidth + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            restart_i,
  input  wire logic [WW-1:0]   width_i,
  input  wire logic [RowW-1:0] height_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            action_i,
  input  wire logic [PixW-1:0] pixel_i,
  output logic                 push_o,
  output nms_item_t            item_o,
  output logic [CW-1:0]        xm_o,
  input  wire logic            full_i
);

  front_state_e state_q, state_d;
  logic [RowW-1:0] r_q, r_d;
  logic [CW-1:0]   c_q, c_d;
  logic            accept;

  // Position bookkeeping for the current request.
  logic [WW-1:0]   c_ext, c_inc, xm_w, x_pos;
  logic [RowW-1:0] ym, y_pos;
  logic [CW-1:0]   xm;
  logic            have, pos_valid, interior, last, center;
  logic [PixW-1:0] pix_v;

  logic [PixW-1:0] pix_mem [2**(CW+1)];
  logic [PixW-1:0] top_q, mid_q, v_q;
  logic [PixW-1:0] win_q [9];

  logic            have_q, valid_q, interior_q, last_q, slot_q, center_q;
  logic [CW-1:0]   xm_q;
  logic signed [GradW-1:0] sx_q, sy_q;
  logic [GradW-1:0] left, right, upper, lower;
  logic [AbsW-1:0] ax, ay;
  logic [MagW-1:0] magsq_q;
  logic [ProdW-1:0] lhs_q, lo_q, hi_q;
  logic            neg_q, zero_q;
  sector_e         sec;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    c_ext     = WW'(c_q);
    have      = ((c_q != '0) && (r_q != '0)) || ((c_q == '0) && (r_q >= RowW'(2)));
    ym        = (c_q != '0) ? r_q - RowW'(1) : r_q - RowW'(2);
    xm_w      = (c_q != '0) ? c_ext - WW'(1) : width_i - WW'(1);
    xm        = xm_w[CW-1:0];
    pos_valid = (xm != '0) ? (ym >= RowW'(1)) : (ym >= RowW'(2));
    y_pos     = (xm != '0) ? ym - RowW'(1) : ym - RowW'(2);
    x_pos     = (xm != '0) ? xm_w - WW'(1) : width_i - WW'(1);
    interior  = (y_pos != '0) && (y_pos <= height_i - RowW'(2)) &&
                (x_pos != '0) && (x_pos <= width_i - WW'(2));
    last      = have && pos_valid && (y_pos == height_i - RowW'(1)) &&
                (x_pos == width_i - WW'(1));
    center    = (c_q >= CW'(2)) && (r_q >= RowW'(2)) && (r_q < height_i);
    pix_v     = (!action_i && (r_q < height_i)) ? pixel_i : '0;
    c_inc     = c_ext + WW'(1);
    r_d       = r_q;
    c_d       = c_q;
    if (restart_i) begin
      r_d = '0;
      c_d = '0;
    end else if (accept) begin
      if (last) begin
        r_d = '0;
        c_d = '0;
      end else if (c_inc >= width_i) begin
        c_d = '0;
        r_d = r_q + RowW'(1);
      end else begin
        c_d = c_inc[CW-1:0];
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FrIdle:   if (accept) state_d = FrWindow;
      FrWindow: state_d = FrGrad;
      FrGrad:   state_d = FrMag;
      FrMag:    state_d = FrPush;
      FrPush:   if (!have_q || !full_i) state_d = FrIdle;
      default:  state_d = FrIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = (state_q == FrIdle);
    push_o     = (state_q == FrPush) && have_q && !full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      r_q     <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
    end
  end

  // Two pixel rows; the old entry is read before the new pixel replaces it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_q <= pix_mem[{r_q[0], c_q}];
      mid_q <= pix_mem[{~r_q[0], c_q}];
      pix_mem[{r_q[0], c_q}] <= pix_v;
    end
  end

  always_comb begin
    left  = GradW'(win_q[0]) + (GradW'(win_q[3]) << 1) + GradW'(win_q[6]);
    right = GradW'(win_q[2]) + (GradW'(win_q[5]) << 1) + GradW'(win_q[8]);
    upper = GradW'(win_q[0]) + (GradW'(win_q[1]) << 1) + GradW'(win_q[2]);
    lower = GradW'(win_q[6]) + (GradW'(win_q[7]) << 1) + GradW'(win_q[8]);
    ax    = sx_q[GradW-1] ? AbsW'(-sx_q) : AbsW'(sx_q);
    ay    = sy_q[GradW-1] ? AbsW'(-sy_q) : AbsW'(sy_q);
    sec   = sector_of(neg_q, zero_q, lhs_q, lo_q, hi_q);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q        <= pix_v;
      have_q     <= have;
      valid_q    <= pos_valid;
      interior_q <= interior;
      last_q     <= last;
      slot_q     <= ym[0];
      center_q   <= center;
      xm_q       <= xm;
    end
    if (state_q == FrWindow) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[2] <= top_q;
      win_q[5] <= mid_q;
      win_q[8] <= v_q;
    end
    if (state_q == FrGrad) begin
      sx_q <= signed'(right - left);
      sy_q <= signed'(lower - upper);
    end
    if (state_q == FrMag) begin
      magsq_q <= MagW'({1'b0, ax} * {1'b0, ax} + {1'b0, ay} * {1'b0, ay});
      lhs_q   <= ProdW'({ay, 24'h000000});
      lo_q    <= ProdW'(TanLo) * ProdW'(ax);
      hi_q    <= ProdW'(TanHi) * ProdW'(ax);
      // After folding sy to be non-negative, sx changes sign when sy was negative.
      neg_q   <= sy_q[GradW-1] ? (sx_q > 0) : sx_q[GradW-1];
      zero_q  <= (sx_q == '0) && (sy_q == '0);
    end
  end

  always_comb begin
    item_o.out_valid = valid_q;
    item_o.interior  = interior_q;
    item_o.last      = last_q;
    item_o.slot      = slot_q;
    item_o.magsq     = center_q ? magsq_q : '0;
    item_o.sector    = center_q ? sec : SecHorz;
    xm_o             = xm_q;
  end

endmodule
`default_nettype wire

FILE: src/sgnms_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Suppression back end
// Keeps two magnitude rows and one sector row, compares each pixel with its
// neighbors along the gradient, and takes the integer square root.
// ----------------------------------------------------------------------------
module sgnms_back import sgnms_pkg::*; #(
  parameter  int unsigned MaxWidth = MaxWidthDefault,
  localparam int unsigned CW       = $clog2(MaxWidth)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  output logic                  pop_o,
  input  wire nms_item_t        item_i,
  input  wire logic [CW-1:0]    xm_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [EdgeW-1:0]      edge_value_o,
  output logic                  frame_end_o
);

  back_state_e state_q, state_d;

  logic [MagW-1:0] mag_mem [2**(CW+1)];
  logic [1:0]      sec_mem [2**CW];
  logic [MagW-1:0] old_q, midm_q;
  logic [1:0]      secrd_q;
  nms_item_t       e_q;
  logic [MagW-1:0] m_q [9];
  sector_e         held_q, sel_q;

  logic [SqrtW-1:0] n_q, root_q, bit_q, sum;
  logic [MagW-1:0]  m1, m2;
  logic             keep;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle:   if (!empty_i) state_d = BkWindow;
      BkWindow: state_d = BkNms;
      BkNms:    state_d = e_q.out_valid ? BkSqrt : BkIdle;
      BkSqrt:   if (bit_q[0]) state_d = BkOut;
      BkOut:    if (out_ready_i) state_d = BkIdle;
      default:  state_d = BkIdle;
    endcase
  end

  always_comb begin
    pop_o        = (state_q == BkIdle) && !empty_i;
    out_valid_o  = (state_q == BkOut);
    edge_value_o = root_q[EdgeW-1:0];
    frame_end_o  = e_q.last;
  end

  always_comb begin
    unique case (sel_q)
      SecHorz:   begin m1 = m_q[3]; m2 = m_q[5]; end
      SecDiagUp: begin m1 = m_q[2]; m2 = m_q[6]; end
      SecVert:   begin m1 = m_q[1]; m2 = m_q[7]; end
      default:   begin m1 = m_q[0]; m2 = m_q[8]; end
    endcase
    keep = e_q.interior && (m_q[4] >= m1) && (m_q[4] >= m2);
    sum  = root_q + bit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      held_q  <= SecHorz;
    end else begin
      state_q <= state_d;
      if (state_q == BkWindow) held_q <= sector_e'(secrd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      old_q   <= mag_mem[{item_i.slot, xm_i}];
      midm_q  <= mag_mem[{~item_i.slot, xm_i}];
      mag_mem[{item_i.slot, xm_i}] <= item_i.magsq;
      secrd_q <= sec_mem[xm_i];
      sec_mem[xm_i] <= item_i.sector;
      e_q     <= item_i;
    end
    if (state_q == BkWindow) begin
      m_q[0] <= m_q[1];
      m_q[1] <= m_q[2];
      m_q[3] <= m_q[4];
      m_q[4] <= m_q[5];
      m_q[6] <= m_q[7];
      m_q[7] <= m_q[8];
      m_q[2] <= old_q;
      m_q[5] <= midm_q;
      m_q[8] <= e_q.magsq;
      // The sector that steers this result was fetched on the previous request.
      sel_q  <= held_q;
    end
    if (state_q == BkNms) begin
      n_q    <= keep ? SqrtW'(m_q[4]) : '0;
      root_q <= '0;
      bit_q  <= SqrtW'(1) << (MagW - 1);
    end
    if (state_q == BkSqrt) begin
      if (n_q >= sum) begin
        n_q    <= n_q - sum;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule
`default_nettype wire

FILE: src/sobel_gradient_nonmax_suppression_unit.sv
`default_nettype none
// An accepted pixel passes the gradient front end (window, gradient, magnitude
// and push states), the queue and the suppression back end before its result.
// The front end takes a new pixel request only when done with the last one and waits
// while the queue is full; requests that produce a result hold the back end for the 11-step square root.
// Reset: width 640, height 480, position and control cleared; row buffers are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Sobel gradient with non-maximum suppression
// Raster pixel stream in, suppressed edge magnitude stream out.
// ----------------------------------------------------------------------------
module sobel_gradient_nonmax_suppression_unit import sgnms_pkg::*; #(
  parameter  int unsigned MaxWidth = MaxWidthDefault,
  localparam int unsigned CW       = $clog2(MaxWidth),
  localparam int unsigned WW       = $clog2(MaxWidth + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  sgnms_pix_if.sink                pix_i,
  sgnms_res_if.source              res_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned WidthInit = (WidthReset < MaxWidth) ? WidthReset : MaxWidth;

  logic [WW-1:0]   width_q, width_d;
  logic [RowW-1:0] height_q, height_d;
  logic [10:0]     wv;
  logic [RowW-1:0] hv;
  logic            restart;

  nms_item_t       item;
  logic [CW-1:0]   xm;
  logic            push, full, pop, empty;
  logic [$bits(nms_item_t)+CW-1:0] q_out;

  always_comb begin
    wv       = cfg_data_i[10:0];
    hv       = cfg_data_i[RowW-1:0];
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i && (cfg_index_i == CfgIdxWidth)) begin
      if (32'(wv) < DimMin) width_d = WW'(DimMin);
      else if (32'(wv) > MaxWidth) width_d = WW'(MaxWidth);
      else width_d = WW'(wv);
    end
    if (cfg_we_i && (cfg_index_i == CfgIdxHeight)) begin
      if (32'(hv) < DimMin) height_d = RowW'(DimMin);
      else if (32'(hv) > HeightMax) height_d = RowW'(HeightMax);
      else height_d = hv;
    end
    restart = cfg_we_i && ((cfg_index_i == CfgIdxWidth) || (cfg_index_i == CfgIdxHeight));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(WidthInit);
      height_q <= RowW'(HeightReset);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  sgnms_front #(.MaxWidth(MaxWidth)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .width_i    (width_q),
    .height_i   (height_q),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .action_i   (pix_i.action),
    .pixel_i    (pix_i.pixel),
    .push_o     (push),
    .item_o     (item),
    .xm_o       (xm),
    .full_i     (full)
  );

  sgnms_queue #(.DataW($bits(nms_item_t) + CW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({item, xm}),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (empty)
  );

  sgnms_back #(.MaxWidth(MaxWidth)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .pop_o        (pop),
    .item_i       (nms_item_t'(q_out[$bits(nms_item_t)+CW-1:CW])),
    .xm_i         (q_out[CW-1:0]),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .edge_value_o (res_o.edge_value),
    .frame_end_o  (res_o.frame_end)
  );

endmodule
`default_nettype wire

FILE: src/sgnms_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel checker
// Port-level properties of the edge result stream.
// ----------------------------------------------------------------------------
module sgnms_checker import sgnms_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             valid_i,
  input wire logic             ready_i,
  input wire logic [EdgeW-1:0] edge_value_i,
  input wire logic             frame_end_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> $stable(edge_value_i) && $stable(frame_end_i))
    else $error("result payload changed while stalled");

  // The last pixel of a frame sits on the border, so it never carries an edge.
  a_frame_end_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && frame_end_i |-> edge_value_i == '0)
    else $error("frame end result carries a nonzero edge");

  a_edge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> edge_value_i <= EdgeW'(1442))
    else $error("edge value above the largest Sobel magnitude");

endmodule

bind sobel_gradient_nonmax_suppression_unit sgnms_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (res_o.valid),
  .ready_i      (res_o.ready),
  .edge_value_i (res_o.edge_value),
  .frame_end_i  (res_o.frame_end)
);
`default_nettype wire
